[rtl/assert_macros.svh]
// Assertion macros for the RTL file that checks its own logic.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk outside reset.
`define ADM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ADM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant checked on every rising edge of clk outside reset.
`define ADM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

[rtl/adm_pkg.sv]
// Package for the adaptive delta modulator: widths, types, codes, state enum.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package adm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int ACC_BITS       = 24;
    localparam int MAX_STEP_EXP   = 15;
    localparam int EXP_BITS       = 4;
    localparam int RUN_BITS       = 3;
    localparam int CNT_BITS       = 10;
    localparam int CFG_DATA_BITS  = 10;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [EXP_BITS-1:0]           exp_t;
    typedef logic signed [RUN_BITS-1:0]    run_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;

    localparam exp_t EXP_ZERO = exp_t'(0);
    localparam exp_t EXP_ONE  = exp_t'(1);
    localparam exp_t EXP_MAX  = exp_t'(MAX_STEP_EXP);

    localparam run_t RUN_ZERO    = run_t'(0);
    localparam run_t RUN_ONE     = run_t'(1);
    localparam run_t RUN_NEG_ONE = run_t'(-1);
    localparam run_t RUN_MAX     = run_t'(3);
    localparam run_t RUN_MIN     = run_t'(-3);
    localparam run_t RUN_RESET   = run_t'(1);

    localparam acc_t ACC_ONE = acc_t'(1);
    localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ADAPTIVE_ENABLE  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERSAMPLE_COUNT = CFG_INDEX_BITS'(1);

    localparam cnt_t OVERSAMPLE_RESET = cnt_t'(16);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PUSH
    } adm_state_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic load_target;
        logic step_en;
        logic load_out;
    } adm_ctrl_t;

    // One tracking step's outcome
    typedef struct packed {
        acc_t approx;
        exp_t exp;
        run_t run;
        logic hit;
    } step_res_t;

endpackage

[rtl/adm_step_unit.sv]
// Shared tracking step unit: one adaptive delta step per use.
// Depends on adm_pkg.
`timescale 1ns / 1ps

module adm_step_unit
    import adm_pkg::*;
(
    input  acc_t      approx,
    input  acc_t      target,
    input  exp_t      exp_in,
    input  run_t      run_in,
    input  logic      adapt,
    output step_res_t res
);

    logic                  down;
    exp_t                  e;
    run_t                  r;
    acc_t                  step;
    logic signed [ACC_BITS:0] ext_a;
    logic signed [ACC_BITS:0] ext_s;
    logic signed [ACC_BITS:0] sum;
    acc_t                  sat;

    always_comb
    begin
        down = (approx >= target);
        e    = exp_in;
        r    = run_in;
        if (adapt)
        begin
            if (down)
            begin
                if (run_in > RUN_ZERO)
                begin
                    e = (exp_in == EXP_ZERO) ? exp_in : exp_in - EXP_ONE;
                    r = RUN_ZERO;
                end
                else if (run_in < RUN_NEG_ONE)
                begin
                    e = (exp_in == EXP_MAX) ? exp_in : exp_in + EXP_ONE;
                end
                if (r > RUN_MIN)
                begin
                    r = r - RUN_ONE;
                end
            end
            else
            begin
                if (run_in < RUN_ZERO)
                begin
                    e = (exp_in == EXP_ZERO) ? exp_in : exp_in - EXP_ONE;
                    r = RUN_ZERO;
                end
                else if (run_in > RUN_ONE)
                begin
                    e = (exp_in == EXP_MAX) ? exp_in : exp_in + EXP_ONE;
                end
                if (r < RUN_MAX)
                begin
                    r = r + RUN_ONE;
                end
            end
        end

        step  = adapt ? (ACC_ONE << e) : ACC_ONE;
        ext_a = {approx[ACC_BITS-1], approx};
        ext_s = {1'b0, step};
        sum   = down ? (ext_a - ext_s) : (ext_a + ext_s);

        // saturate on overflow of the accumulator range
        if (sum[ACC_BITS] != sum[ACC_BITS-1])
        begin
            sat = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sat = sum[ACC_BITS-1:0];
        end

        res.approx = sat;
        res.exp    = e;
        res.run    = r;
        res.hit    = (sat == target) && (step == ACC_ONE);
    end

endmodule

[rtl/adm_ctrl.sv]
// Sequencer: accepts an item, counts tracking steps, hands off the result.
// Depends on adm_pkg.
`timescale 1ns / 1ps

module adm_ctrl
    import adm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    input  cnt_t      oversample_count,
    input  logic      hit,
    input  logic      out_free,
    output adm_ctrl_t ctrl
);

    adm_state_t state_reg;
    adm_state_t state_next;
    cnt_t       cnt_reg;
    cnt_t       cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        sample_ready     = 1'b0;
        ctrl.load_target = 1'b0;
        ctrl.step_en     = 1'b0;
        ctrl.load_out    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    ctrl.load_target = 1'b1;
                    cnt_next         = '0;
                    state_next       = S_RUN;
                end
            end
            S_RUN:
            begin
                if (cnt_reg == oversample_count)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    ctrl.step_en = 1'b1;
                    cnt_next     = cnt_reg + cnt_t'(1);
                    if (hit)
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/adaptive_delta_modulator.sv]
// Adaptive delta modulator: an input sample is accepted in the idle state, then tracked by up to
// oversample_count steps, one per cycle through a single shared step unit, stopping early once
// the approximation meets the sample at unit step. When the count runs out, the run state
// notices the end of the loop without a further step. The push state then moves the result
// into the output register, and that move waits while an earlier result still sits there
// untaken. The next item is taken once the result has entered the output register, even
// while that result still waits to be taken.
// Depends on adm_pkg, adm_ctrl, adm_step_unit and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adaptive_delta_modulator
    import adm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  sample_t                   sample,
    output logic                      approximation_valid,
    input  logic                      approximation_ready,
    output acc_t                      approximation,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic      adapt_reg;
    cnt_t      osc_reg;
    acc_t      target_reg;
    acc_t      approx_reg;
    exp_t      exp_reg;
    run_t      run_reg;
    acc_t      out_reg;
    logic      out_valid_reg;
    logic      out_free;
    adm_ctrl_t ctrl;
    step_res_t res;

    assign out_free = !out_valid_reg || approximation_ready;

    adm_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .oversample_count (osc_reg),
        .hit              (res.hit),
        .out_free         (out_free),
        .ctrl             (ctrl)
    );

    adm_step_unit u_step (
        .approx (approx_reg),
        .target (target_reg),
        .exp_in (exp_reg),
        .run_in (run_reg),
        .adapt  (adapt_reg),
        .res    (res)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_reg <= 1'b1;
            osc_reg   <= OVERSAMPLE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ADAPTIVE_ENABLE)
            begin
                adapt_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_OVERSAMPLE_COUNT)
            begin
                osc_reg <= cnt_t'(cfg_data);
            end
        end
    end

    // Tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            approx_reg <= '0;
            exp_reg    <= EXP_ZERO;
            run_reg    <= RUN_RESET;
        end
        else if (ctrl.step_en)
        begin
            approx_reg <= res.approx;
            exp_reg    <= res.exp;
            run_reg    <= res.run;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_target)
        begin
            target_reg <= acc_t'(sample);
        end
        if (ctrl.load_out)
        begin
            out_reg <= approx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (approximation_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign approximation_valid = out_valid_reg;
    assign approximation       = out_reg;

    `ADM_ASSERT_IMPL(a_no_accept_while_busy, ctrl.step_en || ctrl.load_out,
        !sample_ready, "item accepted during a run")
    `ADM_ASSERT_ALWAYS(a_exp_in_range, exp_reg <= EXP_MAX, "step exponent beyond its limit")
    `ADM_ASSERT_ALWAYS(a_run_in_range, run_reg >= RUN_MIN, "run count beyond its limit")
    `ADM_ASSERT_NEXT(a_fixed_step_holds, ctrl.step_en && !adapt_reg,
        $stable(exp_reg) && $stable(run_reg), "step state moved with adaptation off")

endmodule
